// ----- design/utc_pkg.sv -----
// Shared types and constants for the UTF-8 text class scanner.
// No dependencies; imported by every module of the scanner.
`default_nettype none

package utc_pkg;

   localparam int CP_WIDTH = 21;
   localparam int OUT_COUNT_WIDTH = 16;
   localparam int SUB_WIDTH = 3;

   typedef logic [CP_WIDTH-1:0] cp_type;

   // Top bits of a UTF-8 byte that mark its role.
   localparam logic [1:0] CONT_TAG  = 2'b10;
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [4:0] LEAD4_TAG = 5'b11110;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   localparam cp_type CP_HIRA_LO   = 21'h003040;
   localparam cp_type CP_HIRA_HI   = 21'h00309F;
   localparam cp_type CP_KATA_LO   = 21'h0030A0;
   localparam cp_type CP_KATA_HI   = 21'h0030FF;
   localparam cp_type CP_SMALL_LO  = 21'h0031F0;
   localparam cp_type CP_SMALL_HI  = 21'h0031FF;
   localparam cp_type CP_KANJI_LO  = 21'h003400;
   localparam cp_type CP_KANJI_HI  = 21'h009FFF;
   localparam cp_type CP_COMPAT_LO = 21'h00F900;
   localparam cp_type CP_COMPAT_HI = 21'h00FAFF;
   localparam cp_type CP_HWBLK_LO  = 21'h00FF61;
   localparam cp_type CP_HWBLK_HI  = 21'h00FF9F;
   localparam cp_type CP_HWLET_LO  = 21'h00FF66;
   localparam cp_type CP_HWLET_HI  = 21'h00FF9D;
   localparam cp_type CP_UPPER_LO  = 21'h000041;
   localparam cp_type CP_UPPER_HI  = 21'h00005A;
   localparam cp_type CP_LOWER_LO  = 21'h000061;
   localparam cp_type CP_LOWER_HI  = 21'h00007A;
   localparam cp_type CP_LATX_LO   = 21'h0000C0;
   localparam cp_type CP_LATX_HI   = 21'h00024F;
   localparam cp_type CP_FWUP_LO   = 21'h00FF21;
   localparam cp_type CP_FWUP_HI   = 21'h00FF3A;
   localparam cp_type CP_FWLOW_LO  = 21'h00FF41;
   localparam cp_type CP_FWLOW_HI  = 21'h00FF5A;
   localparam cp_type CP_SPACE     = 21'h000020;
   localparam cp_type CP_TAB       = 21'h000009;
   localparam cp_type CP_IDEO_SPACE = 21'h003000;
   localparam cp_type CP_LF        = 21'h00000A;
   localparam cp_type CP_CR        = 21'h00000D;

   // What one byte produces: substitute characters and at most one decoded point.
   typedef struct packed {
      logic [SUB_WIDTH-1:0] sub_count;
      logic                 point_valid;
      cp_type               point;
   } event_type;

   typedef struct packed {
      logic linguistic;
      logic blank;
      logic line_break;
      logic oldform;
      logic hw_block;
      logic kana;
   } class_type;

   function automatic logic is_oldform(input cp_type c);
      logic hit;
      begin
         case (c)
            21'h005BE6, 21'h00820A, 21'h008B83, 21'h008207, 21'h005B78,
            21'h009AD4, 21'h005EE3, 21'h0061C9, 21'h0085DD, 21'h007E23,
            21'h0064E7, 21'h007027, 21'h00975C: hit = 1'b1;
            default: hit = 1'b0;
         endcase
         return hit;
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/utc_classify.sv -----
// Character class lookup for one decoded code point.
// Depends on utc_pkg for the range constants and the old-form kanji list.
`default_nettype none

module utc_classify (
   input  wire utc_pkg::cp_type    point,
   output utc_pkg::class_type      point_class
);
   import utc_pkg::*;

   logic kata;
   logic hw_letter;
   logic latin;
   logic kanji;
   logic hira;
   logic small_kana;

   always_comb begin
      kata       = (point >= CP_KATA_LO) && (point <= CP_KATA_HI);
      hw_letter  = (point >= CP_HWLET_LO) && (point <= CP_HWLET_HI);
      hira       = (point >= CP_HIRA_LO) && (point <= CP_HIRA_HI);
      small_kana = (point >= CP_SMALL_LO) && (point <= CP_SMALL_HI);
      kanji      = ((point >= CP_KANJI_LO) && (point <= CP_KANJI_HI)) ||
                   ((point >= CP_COMPAT_LO) && (point <= CP_COMPAT_HI));
      latin      = ((point >= CP_UPPER_LO) && (point <= CP_UPPER_HI)) ||
                   ((point >= CP_LOWER_LO) && (point <= CP_LOWER_HI)) ||
                   ((point >= CP_LATX_LO) && (point <= CP_LATX_HI)) ||
                   ((point >= CP_FWUP_LO) && (point <= CP_FWUP_HI)) ||
                   ((point >= CP_FWLOW_LO) && (point <= CP_FWLOW_HI));

      point_class.linguistic = hira || kata || kanji || hw_letter || small_kana || latin;
      point_class.blank      = (point == CP_SPACE) || (point == CP_TAB) ||
                               (point == CP_IDEO_SPACE);
      point_class.line_break = (point == CP_LF) || (point == CP_CR);
      point_class.oldform    = is_oldform(point);
      point_class.hw_block   = (point >= CP_HWBLK_LO) && (point <= CP_HWBLK_HI);
      point_class.kana       = kata || hw_letter;
   end

endmodule

`default_nettype wire

// ----- design/utc_decode.sv -----
// Lenient UTF-8 byte decoder: holds a partial form and reports, per byte,
// how many substitute characters and which decoded point it produces. Uses utc_pkg.
`default_nettype none

module utc_decode (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    advance,
   input  wire  [7:0]             data_byte,
   input  wire                    has_byte,
   input  wire                    last,
   output utc_pkg::event_type     byte_event
);
   import utc_pkg::*;

   logic [1:0] held_count_ff, held_count_in;
   logic [2:0] needed_ff, needed_in;
   logic [7:0] lead_ff, lead_in;
   logic [7:0] mid1_ff, mid1_in;
   logic [7:0] mid2_ff, mid2_in;
   logic       start_lead;
   logic [SUB_WIDTH-1:0] sub_count;
   logic       point_valid;
   cp_type     point;

   always_comb begin
      held_count_in = held_count_ff;
      needed_in     = needed_ff;
      lead_in       = lead_ff;
      mid1_in       = mid1_ff;
      mid2_in       = mid2_ff;
      start_lead    = 1'b0;
      sub_count     = '0;
      point_valid   = 1'b0;
      point         = CP_WIDTH'(data_byte);

      if (has_byte) begin
         if (held_count_ff == 2'd0) begin
            start_lead = 1'b1;
         end else if (data_byte[7:6] != CONT_TAG) begin
            // A broken form: every held byte becomes a substitute character.
            sub_count     = SUB_WIDTH'(held_count_ff);
            held_count_in = 2'd0;
            needed_in     = LEN_NONE;
            start_lead    = 1'b1;
         end else if ((3'(held_count_ff) + 3'd1) < needed_ff) begin
            case (held_count_ff)
               2'd1:    mid1_in = data_byte;
               default: mid2_in = data_byte;
            endcase
            held_count_in = held_count_ff + 2'd1;
         end else begin
            point_valid   = 1'b1;
            held_count_in = 2'd0;
            needed_in     = LEN_NONE;
            case (needed_ff)
               LEN_TWO:   point = CP_WIDTH'({lead_ff[4:0], data_byte[5:0]});
               LEN_THREE: point = CP_WIDTH'({lead_ff[3:0], mid1_ff[5:0], data_byte[5:0]});
               default:   point = {lead_ff[2:0], mid1_ff[5:0], mid2_ff[5:0],
                                   data_byte[5:0]};
            endcase
         end

         if (start_lead) begin
            if (!data_byte[7]) begin
               point_valid = 1'b1;
               point       = CP_WIDTH'(data_byte);
            end else if (data_byte[7:5] == LEAD2_TAG) begin
               needed_in     = LEN_TWO;
               lead_in       = data_byte;
               held_count_in = 2'd1;
            end else if (data_byte[7:4] == LEAD3_TAG) begin
               needed_in     = LEN_THREE;
               lead_in       = data_byte;
               held_count_in = 2'd1;
            end else if (data_byte[7:3] == LEAD4_TAG) begin
               needed_in     = LEN_FOUR;
               lead_in       = data_byte;
               held_count_in = 2'd1;
            end else begin
               sub_count = sub_count + SUB_WIDTH'(1);
            end
         end
      end

      // A form still open at the end of the string is flushed as substitutes.
      if (last) begin
         sub_count     = sub_count + SUB_WIDTH'(held_count_in);
         held_count_in = 2'd0;
         needed_in     = LEN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         needed_ff     <= LEN_NONE;
      end else if (advance) begin
         held_count_ff <= held_count_in;
         needed_ff     <= needed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lead_ff <= lead_in;
         mid1_ff <= mid1_in;
         mid2_ff <= mid2_in;
      end
   end

   assign byte_event.sub_count   = sub_count;
   assign byte_event.point_valid = point_valid;
   assign byte_event.point       = point;

endmodule

`default_nettype wire

// ----- design/utf8_text_class_scanner.sv -----
// Top level of the UTF-8 text class scanner: input register, decoder, classifier,
// string accumulators and result register. Uses utc_pkg, utc_decode, utc_classify.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_data_byte, req_has_byte, req_last
//   rsp      out        rsp_valid/rsp_ready  rsp_codepoint_count, rsp_has_linguistic,
//                                            rsp_empty_or_symbol, rsp_junk_surface
//
// One byte per cycle is taken while no string end waits for the output register; a byte
// goes from the input register through the combinational decoder and classifier into the
// accumulators. A result is written from the input register into the output register once that is free.
// Synchronous reset clears the partial form and the accumulators; no clearing pass.
// Only a transaction with last set waits for the output register; others never stall.
`default_nettype none

module utf8_text_class_scanner #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_has_byte,
   input  wire         req_last,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_codepoint_count,
   output logic        rsp_has_linguistic,
   output logic        rsp_empty_or_symbol,
   output logic        rsp_junk_surface
);
   import utc_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_has_ff;
   logic       in_last_ff;
   logic       out_free;
   logic       advance;

   event_type  byte_event;
   class_type  point_class;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH:0]   count_sum;
   logic [SUB_WIDTH-1:0]   count_inc;
   logic linguistic_ff, linguistic_in;
   logic nonspace_ff, nonspace_in;
   logic oldform_ff, oldform_in;
   logic all_halfwidth_ff, all_halfwidth_in;
   logic kana_ff, kana_in;
   logic other_ff, other_in;
   logic has_sub;
   logic pv;

   logic [OUT_COUNT_WIDTH-1:0] count_out;
   logic                       rsp_valid_ff;
   logic [OUT_COUNT_WIDTH-1:0] rsp_count_ff;
   logic                       rsp_ling_ff;
   logic                       rsp_empty_ff;
   logic                       rsp_junk_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_has_ff  <= req_has_byte;
         in_last_ff <= req_last;
      end
   end

   utc_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .data_byte  (in_byte_ff),
      .has_byte   (in_has_ff),
      .last       (in_last_ff),
      .byte_event (byte_event)
   );

   utc_classify u_classify (
      .point       (byte_event.point),
      .point_class (point_class)
   );

   // Substitute characters are never linguistic, never blank and outside the
   // half-width block, so for the flags any number of them acts like one.
   always_comb begin
      has_sub   = byte_event.sub_count != '0;
      pv        = byte_event.point_valid;
      count_inc = byte_event.sub_count + SUB_WIDTH'(pv);
      count_sum = {1'b0, count_ff} + (COUNT_WIDTH+1)'(count_inc);
      count_in  = count_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : count_sum[COUNT_WIDTH-1:0];

      linguistic_in    = linguistic_ff || (pv && point_class.linguistic);
      nonspace_in      = nonspace_ff || has_sub ||
                         (pv && !point_class.blank && !point_class.line_break);
      oldform_in       = oldform_ff || (pv && point_class.oldform);
      all_halfwidth_in = all_halfwidth_ff && !has_sub && !(pv && !point_class.hw_block);
      kana_in          = kana_ff || (pv && point_class.kana);
      other_in         = other_ff || has_sub ||
                         (pv && !point_class.kana && !point_class.blank);
   end

   generate
      if (COUNT_WIDTH > OUT_COUNT_WIDTH) begin : g_count_clip
         assign count_out = (|count_in[COUNT_WIDTH-1:OUT_COUNT_WIDTH]) ?
                            {OUT_COUNT_WIDTH{1'b1}} : count_in[OUT_COUNT_WIDTH-1:0];
      end else begin : g_count_extend
         assign count_out = OUT_COUNT_WIDTH'(count_in);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         linguistic_ff    <= 1'b0;
         nonspace_ff      <= 1'b0;
         oldform_ff       <= 1'b0;
         all_halfwidth_ff <= 1'b1;
         kana_ff          <= 1'b0;
         other_ff         <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            count_ff         <= '0;
            linguistic_ff    <= 1'b0;
            nonspace_ff      <= 1'b0;
            oldform_ff       <= 1'b0;
            all_halfwidth_ff <= 1'b1;
            kana_ff          <= 1'b0;
            other_ff         <= 1'b0;
         end else begin
            count_ff         <= count_in;
            linguistic_ff    <= linguistic_in;
            nonspace_ff      <= nonspace_in;
            oldform_ff       <= oldform_in;
            all_halfwidth_ff <= all_halfwidth_in;
            kana_ff          <= kana_in;
            other_ff         <= other_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_count_ff <= count_out;
         rsp_ling_ff  <= linguistic_in;
         rsp_empty_ff <= (count_in == '0) || !nonspace_in || !linguistic_in;
         rsp_junk_ff  <= (count_in == '0) || oldform_in || all_halfwidth_in ||
                         (kana_in && !other_in);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_codepoint_count = rsp_count_ff;
   assign rsp_has_linguistic  = rsp_ling_ff;
   assign rsp_empty_or_symbol = rsp_empty_ff;
   assign rsp_junk_surface    = rsp_junk_ff;

   // A string without linguistic content is always reported as empty or symbol.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_linguistic |-> rsp_empty_or_symbol)
      else $error("verdict without linguistic content not marked empty_or_symbol");

   // An empty string is both empty-or-symbol and junk.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_codepoint_count == '0) |-> rsp_empty_or_symbol && rsp_junk_surface)
      else $error("empty string verdict inconsistent");

   // Ending a string clears the accumulators for the next one.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> (count_ff == '0) && all_halfwidth_ff && !linguistic_ff &&
                                !other_ff && !kana_ff)
      else $error("accumulators not cleared after the last byte");

   // A held item stalls only when it ends a string and the result register is full.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> in_last_ff && rsp_valid_ff && !rsp_ready)
      else $error("input register stalled without a full result register");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for utf8_text_class_scanner: directed and random byte strings
// with a built-in verdict predictor, random idling and a long receiver hold-off.
// Depends on utc_pkg and the scanner RTL.

module testbench;
   import utc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam cp_type CP_REPLACEMENT = 21'h00FFFD;
   localparam cp_type CP_PROLONG = 21'h0030FC;

   typedef struct packed {
      logic [7:0] value;
      logic       has_byte;
      logic       last_flag;
   } byte_xfer_type;

   typedef struct packed {
      logic [15:0] count;
      logic        linguistic;
      logic        empty_sym;
      logic        junk;
   } scan_verdict_type;

   typedef enum int {
      THEME_MIXED, THEME_KANA, THEME_BLANK, THEME_HALFWIDTH, THEME_LATIN, THEME_KANJI
   } string_theme_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_codepoint_count;
   logic        rsp_has_linguistic;
   logic        rsp_empty_or_symbol;
   logic        rsp_junk_surface;

   utf8_text_class_scanner DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_has_byte        (req_has_byte),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_codepoint_count (rsp_codepoint_count),
      .rsp_has_linguistic  (rsp_has_linguistic),
      .rsp_empty_or_symbol (rsp_empty_or_symbol),
      .rsp_junk_surface    (rsp_junk_surface)
   );

   byte_xfer_type    pending_bytes [$];
   scan_verdict_type expected_verdicts [$];
   logic [7:0]       str_bytes [$];
   byte_xfer_type    drive_next;
   int               queued_items = 0;
   int               sent_items = 0;
   int               verdicts_seen = 0;
   int               error_count = 0;
   int               hold_cycles = 0;
   logic             held_once = 1'b0;
   int               cycle_count = 0;

   // Predictor state for the string in progress.
   logic [7:0]  held_buf [3];
   logic [1:0]  held_n;
   logic [2:0]  need_len;
   logic [15:0] cp_total;
   logic        seen_ling, seen_nonspace, seen_oldform, only_hw, seen_kana, seen_other;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic cp_type oldform_at(input int idx);
      case (idx)
         0: return 21'h005BE6;
         1: return 21'h00820A;
         2: return 21'h008B83;
         3: return 21'h008207;
         4: return 21'h005B78;
         5: return 21'h009AD4;
         6: return 21'h005EE3;
         7: return 21'h0061C9;
         8: return 21'h0085DD;
         9: return 21'h007E23;
         10: return 21'h0064E7;
         11: return 21'h007027;
         default: return 21'h00975C;
      endcase
   endfunction

   task automatic clear_scan_state();
      for (int k = 0; k < 3; k++) held_buf[k] = 8'h00;
      held_n = 2'd0;
      need_len = LEN_NONE;
      cp_total = 16'h0000;
      seen_ling = 1'b0;
      seen_nonspace = 1'b0;
      seen_oldform = 1'b0;
      only_hw = 1'b1;
      seen_kana = 1'b0;
      seen_other = 1'b0;
   endtask

   task automatic tally_point(input cp_type c);
      logic kata, hw_letter, latin, kanji, blank;
      kata = c >= CP_KATA_LO && c <= CP_KATA_HI;
      hw_letter = c >= CP_HWLET_LO && c <= CP_HWLET_HI;
      latin = (c >= CP_UPPER_LO && c <= CP_UPPER_HI) || (c >= CP_LOWER_LO && c <= CP_LOWER_HI)
           || (c >= CP_LATX_LO && c <= CP_LATX_HI) || (c >= CP_FWUP_LO && c <= CP_FWUP_HI)
           || (c >= CP_FWLOW_LO && c <= CP_FWLOW_HI);
      kanji = (c >= CP_KANJI_LO && c <= CP_KANJI_HI) || (c >= CP_COMPAT_LO && c <= CP_COMPAT_HI);
      blank = c == CP_SPACE || c == CP_TAB || c == CP_IDEO_SPACE;
      if (cp_total != 16'hFFFF) cp_total = cp_total + 16'd1;
      if ((c >= CP_HIRA_LO && c <= CP_HIRA_HI) || kata || kanji || hw_letter
          || (c >= CP_SMALL_LO && c <= CP_SMALL_HI) || latin)
         seen_ling = 1'b1;
      if (!blank && c != CP_LF && c != CP_CR) seen_nonspace = 1'b1;
      for (int k = 0; k < 13; k++)
         if (c == oldform_at(k)) seen_oldform = 1'b1;
      if (!(c >= CP_HWBLK_LO && c <= CP_HWBLK_HI)) only_hw = 1'b0;
      if (kata || hw_letter) seen_kana = 1'b1;
      else if (!blank) seen_other = 1'b1;
   endtask

   task automatic flush_partial();
      repeat (held_n) tally_point(CP_REPLACEMENT);
      held_n = 2'd0;
      need_len = LEN_NONE;
   endtask

   task automatic start_form(input logic [7:0] b);
      if (b[7] == 1'b0) begin
         tally_point({13'd0, b});
         return;
      end
      if (b[7:5] == LEAD2_TAG) need_len = LEN_TWO;
      else if (b[7:4] == LEAD3_TAG) need_len = LEN_THREE;
      else if (b[7:3] == LEAD4_TAG) need_len = LEN_FOUR;
      else begin
         tally_point(CP_REPLACEMENT);
         return;
      end
      held_buf[0] = b;
      held_n = 2'd1;
   endtask

   task automatic decode_byte(input logic [7:0] b);
      cp_type c;
      if (held_n == 2'd0) begin
         start_form(b);
         return;
      end
      // A byte that does not continue the open form breaks it and starts anew.
      if (b[7:6] != CONT_TAG) begin
         flush_partial();
         start_form(b);
         return;
      end
      if (int'(held_n) + 1 < int'(need_len)) begin
         held_buf[held_n] = b;
         held_n = held_n + 2'd1;
         return;
      end
      case (need_len)
         LEN_TWO: c = {16'd0, held_buf[0][4:0]};
         LEN_THREE: c = {17'd0, held_buf[0][3:0]};
         default: c = {18'd0, held_buf[0][2:0]};
      endcase
      for (int k = 1; k < held_n; k++) c = (c << 6) | {15'd0, held_buf[k][5:0]};
      c = (c << 6) | {15'd0, b[5:0]};
      held_n = 2'd0;
      need_len = LEN_NONE;
      tally_point(c);
   endtask

   task automatic scan_transaction(input logic [7:0] b, input logic has, input logic fin);
      scan_verdict_type v;
      if (has) decode_byte(b);
      if (fin) begin
         flush_partial();
         v.count = cp_total;
         v.linguistic = seen_ling;
         v.empty_sym = cp_total == 16'd0 || !seen_nonspace || !seen_ling;
         v.junk = cp_total == 16'd0 || seen_oldform || only_hw || (seen_kana && !seen_other);
         expected_verdicts.push_back(v);
         clear_scan_state();
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic cp_type point_in(input cp_type lo, input cp_type hi);
      case ($urandom_range(0, 9))
         0: return lo - 21'd1;
         1: return lo;
         2: return hi;
         3: return hi + 21'd1;
         default: return cp_type'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic cp_type blank_point();
      case ($urandom_range(0, 4))
         0: return CP_SPACE;
         1: return CP_TAB;
         2: return CP_IDEO_SPACE;
         3: return CP_LF;
         default: return CP_CR;
      endcase
   endfunction

   function automatic cp_type mixed_point();
      case ($urandom_range(0, 17))
         0: return cp_type'($urandom_range(0, 'h7F));
         1: return point_in(CP_UPPER_LO, CP_UPPER_HI);
         2: return point_in(CP_LOWER_LO, CP_LOWER_HI);
         3: return blank_point();
         4: return point_in(CP_HIRA_LO, CP_HIRA_HI);
         5: return point_in(CP_KATA_LO, CP_KATA_HI);
         6: return CP_PROLONG;
         7: return point_in(CP_KANJI_LO, CP_KANJI_HI);
         8: return point_in(CP_COMPAT_LO, CP_COMPAT_HI);
         9: return point_in(CP_SMALL_LO, CP_SMALL_HI);
         10: return point_in(CP_HWBLK_LO, CP_HWBLK_HI);
         11: return point_in(CP_HWLET_LO, CP_HWLET_HI);
         12: return point_in(CP_LATX_LO, CP_LATX_HI);
         13: return point_in(CP_FWUP_LO, CP_FWUP_HI);
         14: return point_in(CP_FWLOW_LO, CP_FWLOW_HI);
         15: return oldform_at($urandom_range(0, 12));
         16: return cp_type'($urandom_range(0, 'hFFFF));
         default: return cp_type'($urandom_range('h10000, 'h1FFFFF));
      endcase
   endfunction

   function automatic cp_type theme_point(input string_theme_type theme);
      case (theme)
         THEME_KANA: begin
            case ($urandom_range(0, 4))
               0, 1: return point_in(CP_KATA_LO, CP_KATA_HI);
               2: return point_in(CP_HWLET_LO, CP_HWLET_HI);
               3: return CP_PROLONG;
               default: return blank_point();
            endcase
         end
         THEME_BLANK: return blank_point();
         THEME_HALFWIDTH: return point_in(CP_HWBLK_LO, CP_HWBLK_HI);
         THEME_LATIN: begin
            case ($urandom_range(0, 5))
               0: return point_in(CP_UPPER_LO, CP_UPPER_HI);
               1: return point_in(CP_LOWER_LO, CP_LOWER_HI);
               2: return point_in(CP_LATX_LO, CP_LATX_HI);
               3: return point_in(CP_FWUP_LO, CP_FWUP_HI);
               4: return point_in(CP_FWLOW_LO, CP_FWLOW_HI);
               default: return CP_SPACE;
            endcase
         end
         THEME_KANJI: begin
            case ($urandom_range(0, 3))
               0: return point_in(CP_KANJI_LO, CP_KANJI_HI);
               1: return point_in(CP_COMPAT_LO, CP_COMPAT_HI);
               2: return oldform_at($urandom_range(0, 12));
               default: return point_in(CP_HIRA_LO, CP_HIRA_HI);
            endcase
         end
         default: return mixed_point();
      endcase
   endfunction

   // Appends the UTF-8 form of a point; stretch gives an overlong form, cut drops its tail.
   task automatic encode_point(input cp_type c, input logic stretch, input logic cut);
      logic [7:0] enc [4];
      int len;
      int keep;
      len = c < 'h80 ? 1 : c < 'h800 ? 2 : c < 'h10000 ? 3 : 4;
      if (stretch && len < 4) len++;
      case (len)
         1: enc[0] = c[7:0];
         2: begin
            enc[0] = {LEAD2_TAG, c[10:6]};
            enc[1] = {CONT_TAG, c[5:0]};
         end
         3: begin
            enc[0] = {LEAD3_TAG, c[15:12]};
            enc[1] = {CONT_TAG, c[11:6]};
            enc[2] = {CONT_TAG, c[5:0]};
         end
         default: begin
            enc[0] = {LEAD4_TAG, c[20:18]};
            enc[1] = {CONT_TAG, c[17:12]};
            enc[2] = {CONT_TAG, c[11:6]};
            enc[3] = {CONT_TAG, c[5:0]};
         end
      endcase
      keep = (cut && len > 1) ? $urandom_range(1, len - 1) : len;
      for (int k = 0; k < keep; k++) str_bytes.push_back(enc[k]);
   endtask

   task automatic queue_item(input logic [7:0] val, input logic has, input logic fin);
      byte_xfer_type x;
      x.value = val;
      x.has_byte = has;
      x.last_flag = fin;
      pending_bytes.push_back(x);
      if (has || fin) queued_items++;
   endtask

   task automatic queue_random_string();
      string_theme_type theme;
      int n;
      int roll;
      logic end_on_byte;
      theme = string_theme_type'($urandom_range(0, 5));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
      str_bytes.delete();
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            // Stray continuation byte or a byte that can never lead a form.
            str_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range('h80, 'hBF)
                                                        : $urandom_range('hF8, 'hFF)));
         end else begin
            encode_point(($urandom_range(0, 9) != 0) ? theme_point(theme) : mixed_point(),
                         $urandom_range(0, 19) == 0, roll < 8);
         end
      end
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 8)) str_bytes.push_back(8'($urandom_range(0, 255)));
      end_on_byte = str_bytes.size() != 0 && $urandom_range(0, 1) == 1;
      foreach (str_bytes[i]) begin
         if ($urandom_range(0, 19) == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         queue_item(str_bytes[i], 1'b1, end_on_byte && i == str_bytes.size() - 1);
      end
      if (!end_on_byte) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_verdict();
      scan_verdict_type want;
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
         report_mismatch("result transaction with no verdict expected");
         return;
      end
      want = expected_verdicts.pop_front();
      if (rsp_codepoint_count !== want.count)
         report_mismatch($sformatf("codepoint_count %0d, expected %0d",
                                   rsp_codepoint_count, want.count));
      if (rsp_has_linguistic !== want.linguistic)
         report_mismatch($sformatf("has_linguistic %b, expected %b",
                                   rsp_has_linguistic, want.linguistic));
      if (rsp_empty_or_symbol !== want.empty_sym)
         report_mismatch($sformatf("empty_or_symbol %b, expected %b",
                                   rsp_empty_or_symbol, want.empty_sym));
      if (rsp_junk_surface !== want.junk)
         report_mismatch($sformatf("junk_surface %b, expected %b",
                                   rsp_junk_surface, want.junk));
   endtask

   function automatic logic sender_idles();
      if (sent_items >= 400 && sent_items < 900) return 1'b0;
      return $urandom_range(0, 99) < 32;
   endfunction

   function automatic logic receiver_idles();
      if (verdicts_seen >= 60 && verdicts_seen < 100) return 1'b0;
      return $urandom_range(0, 99) < 32;
   endfunction

   // ---------------------------------------------------------------- driver and monitor

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            scan_transaction(req_data_byte, req_has_byte, req_last);
            sent_items++;
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && !sender_idles()) begin
               drive_next = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= drive_next.value;
               req_has_byte <= drive_next.has_byte;
               req_last <= drive_next.last_flag;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_verdict();
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (!held_once && verdicts_seen >= 30) begin
            // The result register stays full, so the next string end stalls the input.
            held_once = 1'b1;
            hold_cycles = HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !receiver_idles();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("utf8_text_class_scanner: mismatch");
         $finish;
      end
   end

   initial begin
      int random_goal;
      clear_scan_state();

      // Empty string.
      queue_item(8'h00, 1'b0, 1'b1);
      // Byte extremes, a stray continuation and a byte that can never lead.
      queue_item(8'h00, 1'b1, 1'b0);
      queue_item(8'h80, 1'b1, 1'b0);
      queue_item(8'hFF, 1'b1, 1'b1);
      // Hiragana, closed by its own final byte.
      queue_item(8'hE3, 1'b1, 1'b0);
      queue_item(8'h81, 1'b1, 1'b0);
      queue_item(8'h82, 1'b1, 1'b1);
      // Largest four-byte form, above the Unicode range.
      queue_item(8'hF7, 1'b1, 1'b0);
      queue_item(8'hBF, 1'b1, 1'b0);
      queue_item(8'hBF, 1'b1, 1'b0);
      queue_item(8'hBF, 1'b1, 1'b1);
      // Broken form, an ignored transaction, then a form still open at the end.
      queue_item(8'hE3, 1'b1, 1'b0);
      queue_item(8'h41, 1'b1, 1'b0);
      queue_item(8'hAA, 1'b0, 1'b0);
      queue_item(8'hC3, 1'b1, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1);
      // Old-form kanji.
      queue_item(8'hE5, 1'b1, 1'b0);
      queue_item(8'hAF, 1'b1, 1'b0);
      queue_item(8'hA6, 1'b1, 1'b1);
      // Half-width katakana only.
      queue_item(8'hEF, 1'b1, 1'b0);
      queue_item(8'hBD, 1'b1, 1'b0);
      queue_item(8'hB1, 1'b1, 1'b1);
      // Katakana followed by a space.
      queue_item(8'hE3, 1'b1, 1'b0);
      queue_item(8'h82, 1'b1, 1'b0);
      queue_item(8'hA2, 1'b1, 1'b0);
      queue_item(8'h20, 1'b1, 1'b1);

      random_goal = queued_items + RANDOM_ITEMS;
      while (queued_items < random_goal) queue_random_string();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (pending_bytes.size() != 0 || req_valid);
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("utf8_text_class_scanner: match");
      end else begin
         $display("utf8_text_class_scanner: mismatch");
      end
      $finish;
   end

endmodule

// ----- utf8_text_class_scanner.f -----
design/utc_pkg.sv
design/utc_classify.sv
design/utc_decode.sv
design/utf8_text_class_scanner.sv
dv/testbench.sv
